// ===== hdl/m4vt_pkg.sv =====
// Package: shared types, constants and request codes of the 4x4 matrix-vector transform.
`timescale 1ns / 1ps
package m4vt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_W        = 32;
    localparam int MAT_DIM        = 4;
    localparam int MAT_ENTRIES    = MAT_DIM * MAT_DIM;
    localparam int IDX_W          = $clog2(MAT_ENTRIES);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_XFORM = 2'd2
    } t_req_type;

    typedef enum logic {
        KIND_READ   = 1'b0,
        KIND_VECTOR = 1'b1
    } t_result_kind;

    typedef struct packed {
        t_req_type                   req_type;
        logic [IDX_W-1:0]            elem_index;
        logic signed [FIELD_W-1:0]   elem_value;
        logic signed [FIELD_W-1:0]   vec_x;
        logic signed [FIELD_W-1:0]   vec_y;
        logic signed [FIELD_W-1:0]   vec_z;
        logic signed [FIELD_W-1:0]   vec_w;
    } t_in_item;

    typedef struct packed {
        t_result_kind                result_kind;
        logic signed [FIELD_W-1:0]   out_x;
        logic signed [FIELD_W-1:0]   out_y;
        logic signed [FIELD_W-1:0]   out_z;
        logic signed [FIELD_W-1:0]   out_w;
        logic                        saturated;
    } t_out_item;

endpackage

// ===== hdl/m4vt_matrix_store.sv =====
// Matrix register file: sixteen column-major elements, identity after reset.
`timescale 1ns / 1ps
module m4vt_matrix_store
    import m4vt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [IDX_W-1:0]             i_waddr,
    input  logic signed [DATA_WIDTH-1:0] i_wdata,
    output logic signed [DATA_WIDTH-1:0] o_mat [MAT_ENTRIES]
);

    localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

    logic signed [DATA_WIDTH-1:0] r_mat [MAT_ENTRIES];

    // Diagonal entries sit every MAT_DIM+1 places in column-major order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_ENTRIES; i++) begin
                r_mat[i] <= ((i % (MAT_DIM + 1)) == 0) ? ONE : '0;
            end
        end else if (i_we) begin
            r_mat[i_waddr] <= i_wdata;
        end
    end

    assign o_mat = r_mat;

endmodule

// ===== hdl/m4vt_lane.sv =====
// One row lane: four registered multipliers followed by a registered sum.
`timescale 1ns / 1ps
module m4vt_lane
    import m4vt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_adv,
    input  logic signed [DATA_WIDTH-1:0]          i_elem [MAT_DIM],
    input  logic signed [FIELD_W-1:0]             i_vec  [MAT_DIM],
    output logic signed [DATA_WIDTH+FIELD_W+1:0]  o_sum
);

    localparam int PW   = DATA_WIDTH + FIELD_W;
    localparam int SUMW = PW + 2;

    logic signed [PW-1:0]   r_prod [MAT_DIM];
    logic signed [SUMW-1:0] r_sum;
    logic signed [SUMW-1:0] n_sum;

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < MAT_DIM; c++) begin
            n_sum = n_sum + SUMW'(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < MAT_DIM; c++) begin
                r_prod[c] <= i_elem[c] * i_vec[c];
            end
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hdl/mat4_vector_transform.sv =====
// Top level: 4x4 fixed-point matrix store with a four-lane transform pipeline.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake                   Payload
//  -------  ---------  --------------------------  ----------------------------
//  in       sink       i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  out      source     o_out_valid / i_out_stall   o_out_data (t_out_item)
//
//  One item per cycle is taken while the output is free; a read or transform
//  result passes the input stage, multiplier stage, sum stage and output
//  register after its transfer. Writes give no result.
//  All stages advance together; an output stall holds the whole pipeline
//  and stalls the input side in the same cycle.
//  Synchronous active-low reset clears valids and loads the identity matrix.
module mat4_vector_transform
    import m4vt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int SUMW = DATA_WIDTH + FIELD_W + 2;
    localparam int OW   = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    // Pipeline control
    logic adv;
    logic in_xfer;

    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign in_xfer    = i_in_valid && adv;

    // Matrix store: writes land at the transfer edge
    logic signed [DATA_WIDTH-1:0] mat [MAT_ENTRIES];
    logic signed [OW-1:0]         wval_ext;
    logic                         mat_we;

    assign wval_ext = OW'(i_in_data.elem_value);
    assign mat_we   = in_xfer && (i_in_data.req_type == REQ_WRITE);

    m4vt_matrix_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mat_we),
        .i_waddr (i_in_data.elem_index),
        .i_wdata (wval_ext[DATA_WIDTH-1:0]),
        .o_mat   (mat)
    );

    // Stage 1: latch the request; a read samples its element here
    logic                         r_s1_valid, r_s2_valid, r_s3_valid;
    t_result_kind                 r_s1_kind, r_s2_kind, r_s3_kind;
    logic signed [DATA_WIDTH-1:0] r_s1_rdval, r_s2_rdval, r_s3_rdval;
    logic signed [FIELD_W-1:0]    r_s1_vec [MAT_DIM];
    logic                         n_s1_valid;
    t_result_kind                 n_s1_kind;

    always_comb begin
        n_s1_valid = 1'b0;
        n_s1_kind  = KIND_READ;
        unique case (i_in_data.req_type)
            REQ_READ: begin
                n_s1_valid = in_xfer;
                n_s1_kind  = KIND_READ;
            end
            REQ_XFORM: begin
                n_s1_valid = in_xfer;
                n_s1_kind  = KIND_VECTOR;
            end
            default: begin
                // Write or unused code: nothing travels down the pipe.
                n_s1_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind   <= n_s1_kind;
            r_s1_rdval  <= mat[i_in_data.elem_index];
            r_s1_vec[0] <= i_in_data.vec_x;
            r_s1_vec[1] <= i_in_data.vec_y;
            r_s1_vec[2] <= i_in_data.vec_z;
            r_s1_vec[3] <= i_in_data.vec_w;
            r_s2_kind   <= r_s1_kind;
            r_s2_rdval  <= r_s1_rdval;
            r_s3_kind   <= r_s2_kind;
            r_s3_rdval  <= r_s2_rdval;
        end
    end

    // Stages 2 and 3: one lane per output row
    logic signed [SUMW-1:0]       lane_sum [MAT_DIM];

    for (genvar r = 0; r < MAT_DIM; r++) begin : g_lane
        logic signed [DATA_WIDTH-1:0] row_elem [MAT_DIM];

        for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
            // Column-major: row r of column c sits at c*MAT_DIM + r.
            assign row_elem[c] = mat[c * MAT_DIM + r];
        end

        m4vt_lane #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_lane (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_elem (row_elem),
            .i_vec  (r_s1_vec),
            .o_sum  (lane_sum[r])
        );
    end

    // Merge: floor shift, saturate each row, fold the clip flags
    logic signed [SUMW-1:0]       shifted [MAT_DIM];
    logic signed [DATA_WIDTH-1:0] sat     [MAT_DIM];
    logic signed [OW-1:0]         sat_ext [MAT_DIM];
    logic [MAT_DIM-1:0]           clip;
    logic signed [OW-1:0]         rd_ext;
    t_out_item                    n_out;

    always_comb begin
        for (int r = 0; r < MAT_DIM; r++) begin
            shifted[r] = lane_sum[r] >>> FRAC_BITS;
            // Out of range when the bits above the result's sign disagree.
            clip[r] = (shifted[r][SUMW-1:DATA_WIDTH-1]
                      != {(SUMW-DATA_WIDTH+1){shifted[r][SUMW-1]}});
            if (clip[r]) begin
                sat[r] = {shifted[r][SUMW-1], {(DATA_WIDTH-1){~shifted[r][SUMW-1]}}};
            end else begin
                sat[r] = shifted[r][DATA_WIDTH-1:0];
            end
            sat_ext[r] = OW'(sat[r]);
        end
        rd_ext = OW'(r_s3_rdval);

        n_out.result_kind = r_s3_kind;
        if (r_s3_kind == KIND_VECTOR) begin
            n_out.out_x     = sat_ext[0][FIELD_W-1:0];
            n_out.out_y     = sat_ext[1][FIELD_W-1:0];
            n_out.out_z     = sat_ext[2][FIELD_W-1:0];
            n_out.out_w     = sat_ext[3][FIELD_W-1:0];
            n_out.saturated = |clip;
        end else begin
            n_out.out_x     = rd_ext[FIELD_W-1:0];
            n_out.out_y     = '0;
            n_out.out_z     = '0;
            n_out.out_w     = '0;
            n_out.saturated = 1'b0;
        end
    end

    // Output register
    logic      r_out_valid;
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Assertions
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.req_type == REQ_WRITE)) |=> !r_s1_valid)
        else $error("write transfer entered the result pipeline");

    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && ((i_in_data.req_type == REQ_READ) || (i_in_data.req_type == REQ_XFORM)))
        |=> r_s1_valid)
        else $error("read or transform transfer lost at stage 1");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_s3_valid) && $stable(r_s2_valid) && $stable(r_s1_valid)))
        else $error("pipeline moved while output stalled");

    a_read_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.result_kind == KIND_READ))
        |-> ((r_out_data.out_y == '0) && (r_out_data.out_z == '0)
             && (r_out_data.out_w == '0) && !r_out_data.saturated))
        else $error("read result carries nonzero vector fields");

endmodule
